// File: sv/weo_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the wheel encoder odometry block.
package weo_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE        = 2'd0;
	localparam logic [1:0] REG_SPEED_SCALE = 2'd1;
	localparam logic [1:0] REG_YAW_SCALE   = 2'd2;

	// Kinematic mode codes
	localparam logic [1:0] MODE_MECANUM   = 2'd0;
	localparam logic [1:0] MODE_SKID      = 2'd1;
	localparam logic [1:0] MODE_ACKERMANN = 2'd2;

	localparam int CFG_DATA_W = 24;
	localparam int YAW_MAG_W  = 35;

	// Clamp bound for the yaw operand magnitude
	localparam logic [42:0] YAW_CLAMP = 43'(64'd1 << 34);

	// Commands from controller to datapath
	typedef struct packed {
		logic       capture;   // take a sample beat, form deltas
		logic       mul_wheel; // scale one wheel delta
		logic [1:0] wheel_idx;
		logic       sum_en;    // combine wheel speeds into body terms
		logic       yaw_en;    // yaw rate multiply
		logic       load_out;  // move results into the output register
	} weo_cmd_t;

	// Saturate a sign and magnitude pair to signed 16 bits
	function automatic logic [15:0] sat_mag(input logic neg, input logic [47:0] mag);
		logic [15:0] r;
		if (neg) begin
			r = (mag > 48'd32768) ? 16'h8000 : 16'(~mag[15:0] + 16'd1);
		end else begin
			r = (mag > 48'd32767) ? 16'h7fff : mag[15:0];
		end
		return r;
	endfunction

	// Magnitude of a 43-bit two's complement value
	function automatic logic [42:0] abs43(input logic [42:0] v);
		return v[42] ? 43'(~v + 43'd1) : v;
	endfunction

endpackage

// File: sv/weo_sample_if.sv
`timescale 1ns / 1ps
// Sample channel: four encoder counts and the steering angle.
interface weo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] count_wheel_a;
	logic signed [31:0] count_wheel_b;
	logic signed [31:0] count_wheel_c;
	logic signed [31:0] count_wheel_d;
	logic signed [15:0] steer_angle;

	modport source (output valid, count_wheel_a, count_wheel_b, count_wheel_c,
		count_wheel_d, steer_angle, input ready);
	modport sink (input valid, count_wheel_a, count_wheel_b, count_wheel_c,
		count_wheel_d, steer_angle, output ready);
endinterface

// File: sv/weo_result_if.sv
`timescale 1ns / 1ps
// Result channel: wheel speeds and body velocities.
interface weo_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] speed_wheel_a;
	logic signed [15:0] speed_wheel_b;
	logic signed [15:0] speed_wheel_c;
	logic signed [15:0] speed_wheel_d;
	logic signed [15:0] body_vx;
	logic signed [15:0] body_vy;
	logic signed [15:0] body_vz;

	modport source (output valid, speed_wheel_a, speed_wheel_b, speed_wheel_c,
		speed_wheel_d, body_vx, body_vy, body_vz, input ready);
	modport sink (input valid, speed_wheel_a, speed_wheel_b, speed_wheel_c,
		speed_wheel_d, body_vx, body_vy, body_vz, output ready);
endinterface

// File: sv/weo_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the odometry datapath and owner of the result valid flag.
module weo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output weo_pkg::weo_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_YAW  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic       load;

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign load         = (state_q == ST_DONE) && (!out_valid_q || result_ready);

	// Command decode
	always_comb begin
		cmd.capture   = sample_valid && sample_ready;
		cmd.mul_wheel = (state_q == ST_MUL);
		cmd.wheel_idx = idx_q;
		cmd.sum_en    = (state_q == ST_SUM);
		cmd.yaw_en    = (state_q == ST_YAW);
		cmd.load_out  = load;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (sample_valid) state_d = ST_MUL;
			ST_MUL:  if (idx_q == 2'd3) state_d = ST_SUM;
			ST_SUM:  state_d = ST_YAW;
			ST_YAW:  state_d = ST_DONE;
			ST_DONE: if (load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// State, wheel counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) idx_q <= idx_q + 2'd1;
			else idx_q <= 2'd0;
			if (load) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// File: sv/weo_datapath.sv
`timescale 1ns / 1ps
// Delta capture, shared multiplier, body velocity combine and output register.
module weo_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  weo_pkg::weo_cmd_t               cmd,
	input  logic                            cfg_wr_en,
	input  logic [1:0]                      cfg_index,
	input  logic [weo_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic signed [31:0]              count_wheel_a,
	input  logic signed [31:0]              count_wheel_b,
	input  logic signed [31:0]              count_wheel_c,
	input  logic signed [31:0]              count_wheel_d,
	input  logic signed [15:0]              steer_angle,
	output logic signed [15:0]              speed_wheel_a,
	output logic signed [15:0]              speed_wheel_b,
	output logic signed [15:0]              speed_wheel_c,
	output logic signed [15:0]              speed_wheel_d,
	output logic signed [15:0]              body_vx,
	output logic signed [15:0]              body_vy,
	output logic signed [15:0]              body_vz
);

	localparam int YW = weo_pkg::YAW_MAG_W;

	logic [1:0]  mode_q;
	logic [23:0] speed_scale_q;
	logic [23:0] yaw_scale_q;
	logic [31:0] prev_q [4];
	logic [31:0] cnt_now [4];

	logic [31:0] delta_q [4];
	logic [40:0] w_q [4];
	logic [15:0] steer_q;
	logic [15:0] vx_q;
	logic [15:0] vy_q;
	logic [15:0] vz_q;
	logic [YW-1:0] yaw_mag_q;
	logic          yaw_neg_q;
	logic          yaw_sh16_q;
	logic          body_zero_q;

	assign cnt_now[0] = count_wheel_a;
	assign cnt_now[1] = count_wheel_b;
	assign cnt_now[2] = count_wheel_c;
	assign cnt_now[3] = count_wheel_d;

	// Configuration registers and previous counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= weo_pkg::MODE_MECANUM;
			speed_scale_q <= '0;
			yaw_scale_q   <= '0;
			for (int i = 0; i < 4; i++) prev_q[i] <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					weo_pkg::REG_MODE:        mode_q        <= cfg_data[1:0];
					weo_pkg::REG_SPEED_SCALE: speed_scale_q <= cfg_data;
					weo_pkg::REG_YAW_SCALE:   yaw_scale_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.capture) begin
				for (int i = 0; i < 4; i++) prev_q[i] <= cnt_now[i];
			end
		end
	end

	// Shared multiplier: wheel delta times speed scale, or yaw operand times yaw scale
	logic [31:0]     d_sel;
	logic            d_neg;
	logic [31:0]     d_mag;
	logic [YW-1:0]   mul_a;
	logic [23:0]     mul_b;
	logic [YW+23:0]  prod;
	logic [39:0]     w_mag;
	logic [40:0]     w_new;

	assign d_sel = delta_q[cmd.wheel_idx];
	assign d_neg = d_sel[31];
	assign d_mag = d_neg ? 32'(~d_sel + 32'd1) : d_sel;
	assign mul_a = cmd.yaw_en ? yaw_mag_q : YW'(d_mag);
	assign mul_b = cmd.yaw_en ? yaw_scale_q : speed_scale_q;
	assign prod  = (YW + 24)'(mul_a) * (YW + 24)'(mul_b);
	assign w_mag = prod[55:16];
	assign w_new = d_neg ? 41'(~{1'b0, w_mag} + 41'd1) : {1'b0, w_mag};

	// Body term combine
	logic [42:0] w_x [4];
	logic [42:0] sum4, dify, yaw4, sum2, yaw2, yaw_op;
	logic [42:0] sum4_m, dify_m, sum2_m, yaw_m;
	logic [15:0] vx_new, vy_new;

	always_comb begin
		for (int i = 0; i < 4; i++) w_x[i] = {{2{w_q[i][40]}}, w_q[i]};
		sum4   = w_x[0] + w_x[1] + w_x[2] + w_x[3];
		dify   = w_x[0] - w_x[1] - w_x[2] + w_x[3];
		yaw4   = w_x[0] + w_x[1] - w_x[2] - w_x[3];
		sum2   = w_x[1] + w_x[3];
		yaw2   = w_x[1] - w_x[3];
		yaw_op = (mode_q == weo_pkg::MODE_ACKERMANN) ? yaw2 : yaw4;
		sum4_m = weo_pkg::abs43(sum4);
		dify_m = weo_pkg::abs43(dify);
		sum2_m = weo_pkg::abs43(sum2);
		yaw_m  = weo_pkg::abs43(yaw_op);
		unique case (mode_q)
			weo_pkg::MODE_MECANUM: begin
				vx_new = weo_pkg::sat_mag(sum4[42], 48'(sum4_m >> 2));
				vy_new = weo_pkg::sat_mag(!dify[42], 48'(dify_m >> 2));
			end
			weo_pkg::MODE_SKID: begin
				vx_new = weo_pkg::sat_mag(sum4[42], 48'(sum4_m >> 2));
				vy_new = '0;
			end
			weo_pkg::MODE_ACKERMANN: begin
				vx_new = weo_pkg::sat_mag(sum2[42], 48'(sum2_m >> 1));
				vy_new = steer_q;
			end
			default: begin
				vx_new = '0;
				vy_new = '0;
			end
		endcase
	end

	// Yaw rate: the sign flips, shift depends on mode
	logic [47:0] vz_mag;
	assign vz_mag = yaw_sh16_q ? 48'(prod[YW+23:16]) : 48'(prod[YW+23:18]);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int i = 0; i < 4; i++) delta_q[i] <= cnt_now[i] - prev_q[i];
			steer_q <= steer_angle;
		end
		if (cmd.mul_wheel) w_q[cmd.wheel_idx] <= w_new;
		if (cmd.sum_en) begin
			vx_q        <= vx_new;
			vy_q        <= vy_new;
			yaw_neg_q   <= yaw_op[42];
			yaw_mag_q   <= (yaw_m > weo_pkg::YAW_CLAMP) ? YW'(weo_pkg::YAW_CLAMP) : YW'(yaw_m);
			yaw_sh16_q  <= (mode_q == weo_pkg::MODE_ACKERMANN);
			body_zero_q <= (mode_q != weo_pkg::MODE_MECANUM) && (mode_q != weo_pkg::MODE_SKID)
				&& (mode_q != weo_pkg::MODE_ACKERMANN);
		end
		if (cmd.yaw_en) begin
			vz_q <= body_zero_q ? 16'd0 : weo_pkg::sat_mag(!yaw_neg_q, vz_mag);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			speed_wheel_a <= weo_pkg::sat_mag(w_q[0][40], 48'(weo_pkg::abs43({{2{w_q[0][40]}}, w_q[0]})));
			speed_wheel_b <= weo_pkg::sat_mag(w_q[1][40], 48'(weo_pkg::abs43({{2{w_q[1][40]}}, w_q[1]})));
			speed_wheel_c <= weo_pkg::sat_mag(w_q[2][40], 48'(weo_pkg::abs43({{2{w_q[2][40]}}, w_q[2]})));
			speed_wheel_d <= weo_pkg::sat_mag(w_q[3][40], 48'(weo_pkg::abs43({{2{w_q[3][40]}}, w_q[3]})));
			body_vx       <= vx_q;
			body_vy       <= vy_q;
			body_vz       <= vz_q;
		end
	end

endmodule

// File: sv/wheel_encoder_odometry.sv
`timescale 1ns / 1ps
// A result is offered after MUL, SUM, YAW and DONE; DONE waits on a held result.
// A new sample waits until the last result is loaded; the single shared
// multiplier runs four wheel scalings and one yaw product in turn. The output
// register holds a finished result while the next sample is worked on. Reset
// (arst_n low, asynchronous): previous counts, settings and state clear to zero.
module wheel_encoder_odometry (
	input  logic                           clk,
	input  logic                           arst_n,
	weo_sample_if.sink                     sample,
	weo_result_if.source                   result,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [weo_pkg::CFG_DATA_W-1:0] cfg_data
);

	weo_pkg::weo_cmd_t cmd;

	weo_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd)
	);

	weo_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.count_wheel_a (sample.count_wheel_a),
		.count_wheel_b (sample.count_wheel_b),
		.count_wheel_c (sample.count_wheel_c),
		.count_wheel_d (sample.count_wheel_d),
		.steer_angle   (sample.steer_angle),
		.speed_wheel_a (result.speed_wheel_a),
		.speed_wheel_b (result.speed_wheel_b),
		.speed_wheel_c (result.speed_wheel_c),
		.speed_wheel_d (result.speed_wheel_d),
		.body_vx       (result.body_vx),
		.body_vy       (result.body_vy),
		.body_vz       (result.body_vz)
	);

endmodule

// File: sv/weo_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the odometry block, bound to the top level.
module weo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_vx,
	input logic [15:0] out_vz
);

	// A held result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// A held result beat keeps its body_vx and body_vz payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_vx) && $stable(out_vz))
		else $error("result payload changed while stalled");

	// No sample is taken right after one was taken
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted back to back");

	// The block stays busy through the yaw multiply
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##6 !in_ready)
		else $error("sample ready too early");

endmodule

bind wheel_encoder_odometry weo_checker u_weo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_vx    (result.body_vx),
	.out_vz    (result.body_vz)
);

// File: tb/wheel_encoder_odometry_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for wheel_encoder_odometry against an odometry predictor.
module wheel_encoder_odometry_test;

	// Codes with no package name: the unused mode and the unused register slot
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	typedef struct packed {
		logic [15:0] speed_a;
		logic [15:0] speed_b;
		logic [15:0] speed_c;
		logic [15:0] speed_d;
		logic [15:0] vx;
		logic [15:0] vy;
		logic [15:0] vz;
	} odo_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [1:0]                     cfg_index;
	logic [weo_pkg::CFG_DATA_W-1:0] cfg_data;

	weo_sample_if sample_ch ();
	weo_result_if result_ch ();

	wheel_encoder_odometry DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: last accepted counts and register copies
	logic [3:0][31:0] odo_prev;
	logic [1:0]       odo_mode;
	logic [23:0]      odo_speed_scale;
	logic [23:0]      odo_yaw_scale;

	odo_result_t odo_expected[$];
	int          mismatches;

	// Sender and receiver pacing
	bit        tx_steady;
	int        burst_left;
	rx_style_t rx_style;
	int        rx_hold_off;
	int        rx_phase;

	always #6 clk = ~clk;

	// trunc(v * k / 2^sh) toward zero
	function automatic longint scaled_trunc(input longint v, input logic [23:0] k, input int sh);
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag * k) >> sh;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint clamp_yaw(input longint v);
		longint lim;
		lim = longint'(weo_pkg::YAW_CLAMP);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic logic [15:0] sat16(input longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	// Expected result for one sample; advances the stored counts
	function automatic odo_result_t predict_odometry(input logic [3:0][31:0] counts,
			input logic [15:0] steer);
		logic [31:0] du;
		longint      w [4];
		longint      vx, vy, vz;
		odo_result_t r;
		vx = 0;
		vy = 0;
		vz = 0;
		for (int i = 0; i < 4; i++) begin
			du = counts[i] - odo_prev[i];
			w[i] = scaled_trunc(longint'($signed(du)), odo_speed_scale, 16);
			odo_prev[i] = counts[i];
		end
		case (odo_mode)
			weo_pkg::MODE_MECANUM, weo_pkg::MODE_SKID: begin
				vx = scaled_trunc(w[0] + w[1] + w[2] + w[3], 24'd1, 2);
				if (odo_mode == weo_pkg::MODE_MECANUM)
					vy = -scaled_trunc(w[0] - w[1] - w[2] + w[3], 24'd1, 2);
				vz = -scaled_trunc(clamp_yaw(w[0] + w[1] - w[2] - w[3]), odo_yaw_scale, 18);
			end
			weo_pkg::MODE_ACKERMANN: begin
				vx = scaled_trunc(w[1] + w[3], 24'd1, 1);
				vy = longint'($signed(steer));
				vz = -scaled_trunc(clamp_yaw(w[1] - w[3]), odo_yaw_scale, 16);
			end
			default: ;
		endcase
		r.speed_a = sat16(w[0]);
		r.speed_b = sat16(w[1]);
		r.speed_c = sat16(w[2]);
		r.speed_d = sat16(w[3]);
		r.vx = sat16(vx);
		r.vy = sat16(vy);
		r.vz = sat16(vz);
		return r;
	endfunction

	function automatic logic [31:0] rand_bits(input int bits);
		logic [31:0] v;
		v = $urandom();
		if (bits < 32) v &= (32'd1 << bits) - 32'd1;
		return v;
	endfunction

	// Count step: mostly moderate motion, some crawl, some full-range jumps
	function automatic logic [31:0] rand_delta();
		logic [31:0] d;
		case ($urandom_range(0, 9))
			0: d = $urandom();
			1: d = $urandom_range(0, 3);
			2: d = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
			default: d = rand_bits($urandom_range(0, 20));
		endcase
		if ($urandom_range(0, 1) != 0) d = -d;
		return d;
	endfunction

	// Register write; only called while the block is idle
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			weo_pkg::REG_MODE:        odo_mode = data[1:0];
			weo_pkg::REG_SPEED_SCALE: odo_speed_scale = data;
			weo_pkg::REG_YAW_SCALE:   odo_yaw_scale = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Offer one sample beat, wait for acceptance, then pace the next one
	task automatic send_sample(input logic [3:0][31:0] counts, input logic [15:0] steer);
		@(negedge clk);
		sample_ch.valid = 1'b1;
		sample_ch.count_wheel_a = counts[0];
		sample_ch.count_wheel_b = counts[1];
		sample_ch.count_wheel_c = counts[2];
		sample_ch.count_wheel_d = counts[3];
		sample_ch.steer_angle = steer;
		do @(posedge clk); while (!sample_ch.ready);
		odo_expected.push_back(predict_odometry(counts, steer));
		if (!tx_steady) begin
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 8);
				@(negedge clk);
				sample_ch.valid = 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
		end
	endtask

	// Sample built from per-wheel count steps on top of the last counts
	task automatic send_motion(input logic [31:0] da, db, dc, dd, input logic [15:0] steer);
		logic [3:0][31:0] counts;
		counts[0] = odo_prev[0] + da;
		counts[1] = odo_prev[1] + db;
		counts[2] = odo_prev[2] + dc;
		counts[3] = odo_prev[3] + dd;
		send_sample(counts, steer);
	endtask

	task automatic send_random_sample();
		logic [3:0][31:0] counts;
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < 4; i++) counts[i] = $urandom();
			send_sample(counts, 16'($urandom()));
		end else begin
			send_motion(rand_delta(), rand_delta(), rand_delta(), rand_delta(), 16'($urandom()));
		end
	endtask

	// Stop offering and wait until every expected result is in
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (odo_expected.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// First samples after reset: deltas against zero counts, reset mode
	task automatic test_first_sample();
		write_reg(weo_pkg::REG_SPEED_SCALE, 24'h010000);
		write_reg(weo_pkg::REG_YAW_SCALE, 24'h010000);
		send_sample({32'hffff_fe70, 32'd300, 32'hffff_ff38, 32'd100}, 16'd5);
		send_motion(32'd0, 32'd0, 32'd0, 32'd0, 16'd0);
		drain_results();
	endtask

	// Truncation toward zero, saturation, wrap extremes and the yaw clamp
	task automatic test_rounding_and_limits();
		write_reg(weo_pkg::REG_SPEED_SCALE, 24'h008000);
		send_motion(-32'd1, -32'd3, 32'd3, 32'd1, 16'd0);
		send_motion(-32'd5, 32'd7, -32'd9, 32'd11, 16'd0);
		drain_results();
		write_reg(weo_pkg::REG_SPEED_SCALE, 24'hffffff);
		write_reg(weo_pkg::REG_YAW_SCALE, 24'hffffff);
		send_motion(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd0);
		send_motion(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 16'd0);
		send_motion(32'd1, -32'd1, 32'd1, -32'd1, 16'd0);
		send_motion(32'd0, 32'd0, 32'd0, 32'd0, 16'h7fff);
		drain_results();
		// upper data bits are dropped by the 2-bit mode register
		write_reg(weo_pkg::REG_MODE, 24'hfffffe);
		send_motion(32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_0000, 16'h8000);
		drain_results();
	endtask

	// Every kinematic mode, the unused one included
	task automatic test_mode_sweep();
		logic [1:0] sweep [4];
		sweep = '{weo_pkg::MODE_MECANUM, weo_pkg::MODE_SKID, weo_pkg::MODE_ACKERMANN,
			MODE_UNUSED};
		write_reg(weo_pkg::REG_SPEED_SCALE, 24'h012345);
		write_reg(weo_pkg::REG_YAW_SCALE, 24'h00a000);
		write_reg(REG_UNUSED, 24'hffffff);
		foreach (sweep[m]) begin
			drain_results();
			write_reg(weo_pkg::REG_MODE, 24'(sweep[m]));
			send_motion(32'd1000, -32'd2000, 32'd3000, -32'd400, 16'h8000);
			send_motion(-32'd700, -32'd700, 32'd700, 32'd700, 16'h7fff);
			send_motion(rand_delta(), rand_delta(), rand_delta(), rand_delta(), 16'($urandom()));
		end
		drain_results();
	endtask

	// Receiver holds off while samples keep coming, so the input stalls
	task automatic test_back_pressure();
		write_reg(weo_pkg::REG_MODE, 24'(weo_pkg::MODE_MECANUM));
		write_reg(weo_pkg::REG_SPEED_SCALE, 24'(rand_bits(20)));
		write_reg(weo_pkg::REG_YAW_SCALE, 24'(rand_bits(20)));
		rx_style = RX_RANDOM;
		tx_steady = 1'b1;
		rx_hold_off = 200;
		repeat (12) send_random_sample();
		tx_steady = 1'b0;
		drain_results();
	endtask

	// Random samples over a range of settings and pacing styles
	task automatic test_random_settings();
		logic [23:0] spd, yaw;
		for (int p = 0; p < 9; p++) begin
			drain_results();
			spd = (p == 0) ? 24'hffffff : (p == 5) ? 24'd0 :
				24'(rand_bits($urandom_range(8, 24)));
			yaw = (p == 2) ? 24'hffffff : (p == 3) ? 24'd0 :
				24'(rand_bits($urandom_range(8, 24)));
			write_reg(weo_pkg::REG_MODE, 24'(2'(p % 4)));
			write_reg(weo_pkg::REG_SPEED_SCALE, spd);
			write_reg(weo_pkg::REG_YAW_SCALE, yaw);
			tx_steady = (p == 4);
			rx_style = (p == 4) ? RX_ALWAYS : rx_style_t'(p % 3);
			repeat (100) send_random_sample();
		end
		tx_steady = 1'b0;
		drain_results();
	endtask

	// Receiver ready: a long hold-off when asked, else the current style
	always @(negedge clk) begin
		rx_phase = (rx_phase + 1) % 7;
		if (rx_hold_off > 0) begin
			result_ch.ready = 1'b0;
			rx_hold_off--;
		end else begin
			case (rx_style)
				RX_ALWAYS: result_ch.ready = 1'b1;
				RX_RANDOM: result_ch.ready = ($urandom_range(0, 3) != 0);
				default:   result_ch.ready = (rx_phase < 4);
			endcase
		end
	end

	task automatic check_field(input string name, input logic [15:0] want, got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name,
				$signed(want), $signed(got));
			mismatches++;
		end
	endtask

	// Compare each accepted result beat with the oldest expectation
	initial begin : result_checker
		odo_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (odo_expected.size() == 0) begin
					$display("%0t ns: result beat with none expected: vx %0d vy %0d vz %0d",
						$time, result_ch.body_vx, result_ch.body_vy, result_ch.body_vz);
					mismatches++;
				end else begin
					want = odo_expected.pop_front();
					check_field("speed_wheel_a", want.speed_a, result_ch.speed_wheel_a);
					check_field("speed_wheel_b", want.speed_b, result_ch.speed_wheel_b);
					check_field("speed_wheel_c", want.speed_c, result_ch.speed_wheel_c);
					check_field("speed_wheel_d", want.speed_d, result_ch.speed_wheel_d);
					check_field("body_vx", want.vx, result_ch.body_vx);
					check_field("body_vy", want.vy, result_ch.body_vy);
					check_field("body_vz", want.vz, result_ch.body_vz);
				end
			end
		end
	end

	// Timeout
	initial begin
		#5ms;
		$display("wheel_encoder_odometry test failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = weo_pkg::REG_MODE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.count_wheel_a = '0;
		sample_ch.count_wheel_b = '0;
		sample_ch.count_wheel_c = '0;
		sample_ch.count_wheel_d = '0;
		sample_ch.steer_angle = '0;
		result_ch.ready = 1'b0;
		odo_prev = '0;
		odo_mode = weo_pkg::MODE_MECANUM;
		odo_speed_scale = '0;
		odo_yaw_scale = '0;
		mismatches = 0;
		tx_steady = 1'b0;
		burst_left = 0;
		rx_style = RX_ALWAYS;
		rx_hold_off = 0;
		rx_phase = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_first_sample();
		test_rounding_and_limits();
		test_mode_sweep();
		test_back_pressure();
		test_random_settings();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && odo_expected.size() == 0) begin
			$display("wheel_encoder_odometry test passed");
		end else begin
			$display("wheel_encoder_odometry test failed");
		end
		$finish;
	end

endmodule
